// ----- rtl/pota_pkg.sv -----
// pota_pkg: shared widths, register indexes and stage types
// for the tool-z pose offset block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pota_pkg;

   // quotient bits of one offset component (|offset| <= |distance| < 2^20 + 1)
   localparam int QUO_BITS = 21;
   localparam int NUM_BITS = 55;   // 2*|d*num| + n
   localparam int DEN_BITS = 34;   // 2*n

   // register indexes on the csr port
   localparam logic REG_ENABLE   = 1'b0;
   localparam logic REG_DISTANCE = 1'b1;

   typedef struct packed {
      logic [NUM_BITS-1:0] num_x;
      logic [NUM_BITS-1:0] num_y;
      logic [NUM_BITS-1:0] num_z;
      logic [DEN_BITS-1:0] den;
   } div_in_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               apply;
      logic [2:0]         neg;      // offset sign per axis
   } side_type;

endpackage
`default_nettype wire

// ----- rtl/pota_prep.sv -----
// pota_prep: four-stage front end, quaternion products, column numerators,
// distance products and divider operands; uses pota_pkg
`timescale 1ns / 1ps
`default_nettype none
module pota_prep #(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  wire                       clock,
   input  wire                       en,
   input  wire signed [31:0]         pos_x,
   input  wire signed [31:0]         pos_y,
   input  wire signed [31:0]         pos_z,
   input  wire signed [15:0]         quat_x,
   input  wire signed [15:0]         quat_y,
   input  wire signed [15:0]         quat_z,
   input  wire signed [15:0]         quat_w,
   input  wire signed [20:0]         distance,
   input  wire                       apply,
   output pota_pkg::div_in_type      div_in,
   output pota_pkg::side_type        side
);

   localparam logic [63:0] ZERO_LIM =
      (64'd1 << (2 * QUAT_FRAC_BITS)) / 64'd1000000000000000000;

   // stage 1: products
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [20:0] d1_ff, d2_ff;
   pota_pkg::side_type s1_ff, s2_ff, s3_ff, s4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         ww_ff <= quat_w * quat_w;
         xz_ff <= quat_x * quat_z;
         wy_ff <= quat_w * quat_y;
         yz_ff <= quat_y * quat_z;
         wx_ff <= quat_w * quat_x;
         d1_ff <= distance;
         s1_ff.pos_x <= pos_x;
         s1_ff.pos_y <= pos_y;
         s1_ff.pos_z <= pos_z;
         s1_ff.apply <= apply;
         s1_ff.neg   <= 3'b000;
      end
   end

   // stage 2: squared norm and numerators, identity for a null quaternion
   logic        [32:0] n_in;
   logic signed [34:0] nx_in, ny_in, nz_in;
   logic        [32:0] n_ff;
   logic signed [34:0] nx_ff, ny_ff, nz_ff;

   always_comb begin
      n_in  = 33'($unsigned(xx_ff)) + 33'($unsigned(yy_ff))
            + 33'($unsigned(zz_ff)) + 33'($unsigned(ww_ff));
      nx_in = (35'(xz_ff) + 35'(wy_ff)) <<< 1;
      ny_in = (35'(yz_ff) - 35'(wx_ff)) <<< 1;
      nz_in = 35'(zz_ff) + 35'(ww_ff) - 35'(xx_ff) - 35'(yy_ff);
      if (64'(n_in) <= ZERO_LIM) begin
         n_in  = 33'd1;
         nx_in = '0;
         ny_in = '0;
         nz_in = 35'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff  <= n_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         nz_ff <= nz_in;
         d2_ff <= d1_ff;
         s2_ff <= s1_ff;
      end
   end

   // stage 3: distance times numerator
   logic signed [55:0] px_ff, py_ff, pz_ff;
   logic        [32:0] n3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= 56'(d2_ff) * 56'(nx_ff);
         py_ff <= 56'(d2_ff) * 56'(ny_ff);
         pz_ff <= 56'(d2_ff) * 56'(nz_ff);
         n3_ff <= n_ff;
         s3_ff <= s2_ff;
      end
   end

   // stage 4: magnitudes with round-half term, offset is -d*num so sign flips
   logic [55:0] mx, my, mz;
   pota_pkg::div_in_type div_ff;

   always_comb begin
      mx = px_ff[55] ? 56'(-px_ff) : 56'(px_ff);
      my = py_ff[55] ? 56'(-py_ff) : 56'(py_ff);
      mz = pz_ff[55] ? 56'(-pz_ff) : 56'(pz_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff.num_x <= {mx[52:0], 1'b0} + pota_pkg::NUM_BITS'(n3_ff);
         div_ff.num_y <= {my[52:0], 1'b0} + pota_pkg::NUM_BITS'(n3_ff);
         div_ff.num_z <= {mz[52:0], 1'b0} + pota_pkg::NUM_BITS'(n3_ff);
         div_ff.den   <= {n3_ff, 1'b0};
         s4_ff.pos_x  <= s3_ff.pos_x;
         s4_ff.pos_y  <= s3_ff.pos_y;
         s4_ff.pos_z  <= s3_ff.pos_z;
         s4_ff.apply  <= s3_ff.apply;
         s4_ff.neg    <= {~pz_ff[55], ~py_ff[55], ~px_ff[55]};
      end
   end

   assign div_in = div_ff;
   assign side   = s4_ff;

endmodule
`default_nettype wire

// ----- rtl/pota_div.sv -----
// pota_div: pipelined restoring divider, one quotient bit per stage
// uses pota_pkg widths; quotient must fit in QUO_BITS
`timescale 1ns / 1ps
`default_nettype none
module pota_div (
   input  wire                                clock,
   input  wire                                en,
   input  wire  [pota_pkg::NUM_BITS-1:0]      num,
   input  wire  [pota_pkg::DEN_BITS-1:0]      den,
   output logic [pota_pkg::QUO_BITS-1:0]      quo
);

   localparam int QB = pota_pkg::QUO_BITS;
   localparam int DB = pota_pkg::DEN_BITS;

   logic [DB-1:0] rem_ff [0:QB];
   logic [DB-1:0] den_ff [0:QB];
   logic [QB-1:0] low_ff [0:QB];
   logic [QB-1:0] quo_ff [0:QB];

   // trial subtraction of every stage
   logic [DB:0]   trial [1:QB];
   logic [QB:1]   ge;

   always_comb begin
      for (int k = 1; k <= QB; k++) begin
         trial[k] = {rem_ff[k-1], low_ff[k-1][QB-1]};
         ge[k]    = trial[k] >= {1'b0, den_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num[pota_pkg::NUM_BITS-1:QB];
         low_ff[0] <= num[QB-1:0];
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k] <= ge[k] ? DB'(trial[k] - {1'b0, den_ff[k-1]}) : DB'(trial[k]);
            low_ff[k] <= {low_ff[k-1][QB-2:0], 1'b0};
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= {quo_ff[k-1][QB-2:0], ge[k]};
         end
      end
   end

   assign quo = quo_ff[QB];

endmodule
`default_nettype wire

// ----- rtl/pose_offset_along_tool_z_unit.sv -----
// pose_offset_along_tool_z_unit: top level, csr registers, front end,
// three divider lanes and saturating output; uses pota_pkg, pota_prep, pota_div
`timescale 1ns / 1ps
`default_nettype none
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   pos x/y/z, quat x/y/z/w
//   rsp       out         rsp_valid/rsp_stall   out x/y/z, offset_applied
//   csr       in          apb psel/penable      enable, distance
//
// one transaction per cycle while no result is stalled; the pipeline is 4 front-end
// stages + 22 divider stages + 1 output stage, most of them in the one-bit-per-stage divider
// reset clears the valid bits and restores enable = 1, distance = 6554
// a stalled result freezes the whole pipeline; req_stall is raised only then
//
module pose_offset_along_tool_z_unit #(
   parameter int POS_FRAC_BITS  = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire signed [31:0]  req_pos_x,
   input  wire signed [31:0]  req_pos_y,
   input  wire signed [31:0]  req_pos_z,
   input  wire signed [15:0]  req_quat_x,
   input  wire signed [15:0]  req_quat_y,
   input  wire signed [15:0]  req_quat_z,
   input  wire signed [15:0]  req_quat_w,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_offset_applied,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [2:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int QB  = pota_pkg::QUO_BITS;
   localparam int LAT = 4 + QB + 1 + 1;   // front end, divider, output
   // largest distance magnitude that is not above 1e-6 m
   localparam logic [63:0] GATE_MIN = (64'd1 << POS_FRAC_BITS) / 64'd1000000;

   // ---- csr registers
   logic               enable_ff;
   logic signed [20:0] distance_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         distance_ff <= 21'sd6554;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            pota_pkg::REG_ENABLE:   enable_ff   <= pwdata[0];
            pota_pkg::REG_DISTANCE: distance_ff <= pwdata[20:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         pota_pkg::REG_ENABLE:   prdata = {31'd0, enable_ff};
         pota_pkg::REG_DISTANCE: prdata = 32'(distance_ff);
         default:                prdata = '0;
      endcase
   end

   // offset gate, evaluated per transaction at entry
   logic [20:0] dist_mag;
   logic        apply;
   assign dist_mag = distance_ff[20] ? 21'(-distance_ff) : 21'(distance_ff);
   assign apply    = enable_ff && (64'(dist_mag) > GATE_MIN);

   // ---- pipeline advance: everything moves unless a result sits stalled
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---- front end: products, numerators, divider operands
   pota_pkg::div_in_type div_in;
   pota_pkg::side_type   side4;

   pota_prep #(
      .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .en       (en),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .quat_w   (req_quat_w),
      .distance (distance_ff),
      .apply    (apply),
      .div_in   (div_in),
      .side     (side4)
   );

   // ---- three divider lanes, rounded |d*num| / n
   logic [QB-1:0] quo_x, quo_y, quo_z;

   pota_div u_div_x (.clock(clock), .en(en), .num(div_in.num_x), .den(div_in.den),
                     .quo(quo_x));
   pota_div u_div_y (.clock(clock), .en(en), .num(div_in.num_y), .den(div_in.den),
                     .quo(quo_y));
   pota_div u_div_z (.clock(clock), .en(en), .num(div_in.num_z), .den(div_in.den),
                     .quo(quo_z));

   // position and flags ride alongside the divider
   pota_pkg::side_type side_ff [0:QB];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side4;
         for (int k = 1; k <= QB; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---- output stage: sign, add, saturate
   function automatic logic signed [31:0] add_sat(input logic signed [31:0] pos,
                                                  input logic [QB-1:0] q,
                                                  input logic neg);
      logic signed [QB:0] off;
      logic signed [32:0] sum;
      off = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      sum = 33'(pos) + 33'(off);
      if (sum > 33'sh0_7FFF_FFFF) begin
         add_sat = 32'sh7FFF_FFFF;
      end else if (sum < -33'sh0_8000_0000) begin
         add_sat = 32'sh8000_0000;
      end else begin
         add_sat = sum[31:0];
      end
   endfunction

   pota_pkg::side_type sd;
   assign sd = side_ff[QB];

   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff;
   logic               applied_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff   <= sd.apply ? add_sat(sd.pos_x, quo_x, sd.neg[0]) : sd.pos_x;
         out_y_ff   <= sd.apply ? add_sat(sd.pos_y, quo_y, sd.neg[1]) : sd.pos_y;
         out_z_ff   <= sd.apply ? add_sat(sd.pos_z, quo_z, sd.neg[2]) : sd.pos_z;
         applied_ff <= sd.apply;
      end
   end

   assign rsp_valid          = vld_ff[LAT-1];
   assign rsp_out_x          = out_x_ff;
   assign rsp_out_y          = out_y_ff;
   assign rsp_out_z          = out_z_ff;
   assign rsp_offset_applied = applied_ff;

endmodule
`default_nettype wire

// ----- rtl/pota_checker.sv -----
// pota_checker: port-level assertions for the top level, bound to it
// depends only on the top level's ports
`timescale 1ns / 1ps
`default_nettype none
module pota_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [31:0] rsp_out_x,
   input wire        rsp_offset_applied,
   input wire        pready
);

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow a held result");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_x) && $stable(rsp_offset_applied))
      else $error("result changed while stalled");

endmodule

bind pose_offset_along_tool_z_unit pota_checker u_pota_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_x          (rsp_out_x),
   .rsp_offset_applied (rsp_offset_applied),
   .pready             (pready)
);
`default_nettype wire

// ----- test/pose_offset_along_tool_z_unit_tb.sv -----
// pose_offset_along_tool_z_unit_tb: self-checking bench for the tool-z pose backoff block;
// drives poses, programs the csr port, predicts every result; uses pota_pkg
`timescale 1ns / 1ps
`default_nettype none
module pose_offset_along_tool_z_unit_tb;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] qx, qy, qz, qw;
   } pose_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               applied;
   } backoff_type;

   typedef struct {
      pose_type    p;
      bit          typed;
      backoff_type want;
   } row_type;

   localparam int LATENCY = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_offset_applied;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // predictor copy of the registers
   bit               mdl_enable = 1'b1;
   longint           mdl_distance = 6554;
   backoff_type      pending_backoffs[$];
   row_type          rows[$];
   int               error_count = 0;
   int               sent_count = 0;
   int               checked_count = 0;
   int               applied_count = 0;
   bit               stimulus_done = 1'b0;

   pose_offset_along_tool_z_unit u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // a / den rounded to nearest, ties away from zero
   function automatic longint round_ratio(longint a, longint den);
      longint mag;
      longint q;
      mag = (a < 0) ? -a : a;
      q = (2 * mag + den) / (2 * den);
      return (a < 0) ? -q : q;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic backoff_type predict_backoff(pose_type p);
      backoff_type r;
      longint qx, qy, qz, qw, n, nx, ny, nz, mag;
      bit apply;
      qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
      mag = (mdl_distance < 0) ? -mdl_distance : mdl_distance;
      apply = mdl_enable && (mag * 1000000 > (64'sd1 << 16));
      r.x = p.px; r.y = p.py; r.z = p.pz;
      r.applied = apply;
      if (apply) begin
         n = qx * qx + qy * qy + qz * qz + qw * qw;
         // zero quaternion is taken as identity
         if (n <= ((64'sd1 << 28) / 64'sd1000000000000000000)) begin
            nx = 0; ny = 0; nz = 1; n = 1;
         end else begin
            nx = 2 * (qx * qz + qw * qy);
            ny = 2 * (qy * qz - qw * qx);
            nz = qz * qz + qw * qw - qx * qx - qy * qy;
         end
         r.x = clamp32(longint'(p.px) + round_ratio(-mdl_distance * nx, n));
         r.y = clamp32(longint'(p.py) + round_ratio(-mdl_distance * ny, n));
         r.z = clamp32(longint'(p.pz) + round_ratio(-mdl_distance * nz, n));
      end
      return r;
   endfunction

   function automatic logic signed [15:0] rand_quat_part();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 32) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_position();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff - $urandom_range(0, 7000);
         1: return 32'sh80000000 + $urandom_range(0, 7000);
         2: return $urandom_range(0, 1 << 20) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      p.px = rand_position();
      p.py = rand_position();
      p.pz = rand_position();
      if ($urandom_range(0, 9) == 0) begin
         p.qx = '0; p.qy = '0; p.qz = '0; p.qw = '0;
      end else begin
         p.qx = rand_quat_part();
         p.qy = rand_quat_part();
         p.qz = rand_quat_part();
         p.qw = rand_quat_part();
      end
      return p;
   endfunction

   function automatic pose_type mk_pose(int px, int py, int pz,
                                        int qx, int qy, int qz, int qw);
      pose_type p;
      p.px = px; p.py = py; p.pz = pz;
      p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz); p.qw = 16'(qw);
      return p;
   endfunction

   function automatic void add_row(pose_type p, bit typed, int x, int y, int z, bit a);
      row_type r;
      r.p = p; r.typed = typed;
      r.want.x = x; r.want.y = y; r.want.z = z; r.want.applied = a;
      rows.push_back(r);
   endfunction

   // result side backpressure: mostly short stalls, a few long ones
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 6);
      end
   end

   // predict at input acceptance, compare at output acceptance
   always @(posedge clock) begin
      pose_type    p;
      backoff_type want;
      if (!reset && req_valid && !req_stall) begin
         p = mk_pose(req_pos_x, req_pos_y, req_pos_z,
                     req_quat_x, req_quat_y, req_quat_z, req_quat_w);
         pending_backoffs.push_back(predict_backoff(p));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_backoffs.size() == 0) begin
            $error("result transaction with nothing expected");
            error_count++;
         end else begin
            want = pending_backoffs.pop_front();
            checked_count++;
            if (rsp_offset_applied) applied_count++;
            if (rsp_out_x !== want.x) begin
               $error("out_x expected %0d got %0d", want.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y expected %0d got %0d", want.y, rsp_out_y);
               error_count++;
            end
            if (rsp_out_z !== want.z) begin
               $error("out_z expected %0d got %0d", want.z, rsp_out_z);
               error_count++;
            end
            if (rsp_offset_applied !== want.applied) begin
               $error("offset_applied expected %0d got %0d",
                      want.applied, rsp_offset_applied);
               error_count++;
            end
         end
      end
   end

   // send one pose; valid stays high into the next transaction when no gap follows
   task automatic send_pose(pose_type p);
      int gap;
      req_valid <= 1'b1;
      req_pos_x <= p.px; req_pos_y <= p.py; req_pos_z <= p.pz;
      req_quat_x <= p.qx; req_quat_y <= p.qy;
      req_quat_z <= p.qz; req_quat_w <= p.qw;
      do @(posedge clock); while (req_stall);
      sent_count++;
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 20) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_backoffs.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == pota_pkg::REG_ENABLE) mdl_enable = value[0];
      else mdl_distance = longint'(signed'(value[20:0]));
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   initial begin
      int      en_set[8];
      int      dist_set[8];
      int      n_items;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset defaults: enable 1, distance 6554
      add_row(mk_pose(0, 0, 0, 0, 0, 0, 16384), 1, 0, 0, -6554, 1);
      add_row(mk_pose(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, -6554, 1);
      add_row(mk_pose(0, 0, 32'h7fffffff, 0, 0, 0, 16384), 1, 0, 0, 2147477093, 1);
      // pushing past the negative limit saturates
      add_row(mk_pose(0, 0, 32'h80000000, 0, 0, 0, 16384), 1, 0, 0, 32'h80000000, 1);
      add_row(mk_pose(0, 0, 32'h80000000, 16384, 0, 0, 0), 1, 0, 0, -2147477094, 1);
      add_row(mk_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, -32768), 1,
              32'h7fffffff, 32'h80000000, 2147477093, 1);
      add_row(mk_pose(0, 0, 0, -32768, -32768, -32768, -32768), 1, -6554, 0, 0, 1);
      add_row(mk_pose(0, 0, 0, 32767, 32767, 32767, 32767), 1, -6554, 0, 0, 1);
      add_row(mk_pose(100, -100, 7, 0, 16384, 0, 0), 0, 0, 0, 0, 0);
      add_row(mk_pose(-5, 5, 0, 11585, 0, 0, 11585), 0, 0, 0, 0, 0);
      add_row(mk_pose(1, 2, 3, 32767, -32768, 1, -1), 0, 0, 0, 0, 0);
      add_row(mk_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 16384, 16384, 0), 0,
              0, 0, 0, 0);
      add_row(mk_pose(0, 0, 0, 1, 0, 0, 0), 0, 0, 0, 0, 0);
      foreach (rows[i]) begin
         // typed rows must agree with the predictor too
         if (rows[i].typed && predict_backoff(rows[i].p) != rows[i].want) begin
            $error("directed row %0d: typed result disagrees with prediction", i);
            error_count++;
         end
         send_pose(rows[i].p);
      end
      drain();

      // settings walked by the random part, extremes included
      en_set   = '{1, 0, 1, 1, 1, 1, 1, 1};
      dist_set = '{6554, 6554, 0, 1048575, -1048576, -1, 1, 0};
      dist_set[7] = $urandom_range(0, 2097151) - 1048576;
      foreach (en_set[ph]) begin
         csr_write(pota_pkg::REG_ENABLE, en_set[ph]);
         csr_write(pota_pkg::REG_DISTANCE, dist_set[ph]);
         n_items = 68;
         for (int k = 0; k < n_items; k++) begin
            // mid-phase pause in phase 3 until every result is back
            if (ph == 3 && k == n_items / 2) begin
               req_valid <= 1'b0;
               while (pending_backoffs.size() != 0) @(posedge clock);
            end
            send_pose(rand_pose());
         end
         drain();
      end
      stimulus_done = 1'b1;

      $display("sent %0d poses over %0d register settings, %0d results checked, %0d with offset",
               sent_count, 9, checked_count, applied_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/pota_pkg.sv
rtl/pota_prep.sv
rtl/pota_div.sv
rtl/pose_offset_along_tool_z_unit.sv
rtl/pota_checker.sv
test/pose_offset_along_tool_z_unit_tb.sv
